[design/particle_kinematics_fade_update_top_macros.svh]
// Assertion helpers shared by the particle update design.
// Both expect signals named clk and arst_n in the calling scope.
`ifndef PARTICLE_KINEMATICS_FADE_UPDATE_TOP_MACROS_SVH
`define PARTICLE_KINEMATICS_FADE_UPDATE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKFU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PKFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pkfu_pkg.sv]
package pkfu_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [31:0] SIZE_RESET = 32'(1) << (FRAC_BITS - 3);

	// Serial multiplier: A operand width, B operand width (one bit per cycle).
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// Serial restoring divider: one quotient bit per cycle.
	localparam int DIV_N_W = 66;
	localparam int DIV_D_W = 42;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	localparam logic [DIV_D_W-1:0] STEP_DIV = DIV_D_W'(1000);
	localparam logic [DIV_N_W-1:0] STEP_HALF = DIV_N_W'(500);
	localparam logic [25:0] T_MAX = 26'(1) << 25;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_LOAD_AXIS = 2'd1,
		OP_LOAD_SPIN = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_LIFE     = 3'd0,
		CFG_FBEGIN   = 3'd1,
		CFG_FFINISH  = 3'd2,
		CFG_FRATE    = 3'd3,
		CFG_FON      = 3'd4,
		CFG_START    = 3'd5,
		CFG_TARGET   = 3'd6,
		CFG_UNUSED   = 3'd7
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_AMUL,
		S_AMUL_W,
		S_ADIV,
		S_ADIV_W,
		S_AWB,
		S_F_BL,
		S_F_BL_W,
		S_F_DEN,
		S_F_DEN_W,
		S_F_NUM,
		S_FDIV_W,
		S_F_T,
		S_F_T_W,
		S_F_CH,
		S_F_CH_W,
		S_WB
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[design/pkfu_mul.sv]
// Shift-add multiplier, one bit of the B operand per cycle.
module pkfu_mul import pkfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output unit_stat_t         stat,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_P_W-1:0]   p_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MUL_A_W:0]     upper;

	assign upper = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {upper, p_q[MUL_B_W-1:1]};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign prod = p_q;

endmodule

[design/pkfu_div.sv]
// Restoring divider, one quotient bit per cycle.
module pkfu_div import pkfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output unit_stat_t         stat,
	output logic [DIV_N_W-1:0] quotient
);

	logic [DIV_D_W-1:0]   d_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W+1:0]   trial;

	assign trial = {1'b0, rem_q, quo_q[DIV_N_W-1]} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (trial[DIV_D_W+1]) begin
				rem_q <= {rem_q[DIV_D_W-2:0], quo_q[DIV_N_W-1]};
			end else begin
				rem_q <= trial[DIV_D_W-1:0];
			end
			quo_q <= {quo_q[DIV_N_W-2:0], ~trial[DIV_D_W+1]};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;

endmodule

[design/particle_kinematics_fade_update_top.sv]
// A load or clear item goes from idle straight to write-back; m_axis_tvalid rises after
// write-back once the output register is free. A tick runs eight integration steps, each
// a multiply then a divide on the shared serial multiplier and serial divider, and with
// fading on then computes the fade fraction and four colour channels on the same units.
// One item at a time: a new item is accepted only in idle, after write-back of the last.
// Reset (arst_n low): configuration and particle state take their reset values at once.
`include "particle_kinematics_fade_update_top_macros.svh"

module particle_kinematics_fade_update_top import pkfu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// value_a [31:0], value_b [63:32], value_c [95:64], value_d [127:96],
	// delta_ms [143:128]
	input  logic [143:0] s_axis_tdata,
	// operation [1:0], axis [3:2]
	input  logic [3:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x [31:0], pos_y [63:32], pos_z [95:64], prev_x [127:96],
	// prev_y [159:128], prev_z [191:160], angle [223:192], extent [255:224],
	// colour_out [287:256], elapsed_out [319:288]
	output logic [319:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// Configuration registers.
	logic [23:0] life_q;
	logic [16:0] fbegin_q;
	logic [16:0] ffinish_q;
	logic [15:0] frate_q;
	logic        fon_q;
	logic [31:0] start_q;
	logic [31:0] target_q;

	// Particle state.
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];
	logic signed [31:0] old_q [3];
	logic signed [31:0] rot_q;
	logic signed [31:0] spin_q;
	logic signed [31:0] siz_q;
	logic signed [31:0] grow_q;
	logic [31:0]        elapsed_q;
	logic [31:0]        colour_q;

	// Sequencer.
	state_t      state_q;
	state_t      state_nxt;
	logic [2:0]  k_q;
	logic [1:0]  ch_q;
	logic [15:0] delta_q;
	logic [40:0] bl_q;
	logic [40:0] d_q;
	logic        num_neg_q;
	logic [33:0] r_q;
	logic [25:0] t_mag_q;
	logic        t_neg_q;
	logic        out_valid_q;
	logic [319:0] out_q;

	// Shared arithmetic units.
	logic               mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	unit_stat_t         mul_st;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_start;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	unit_stat_t         div_st;
	logic [DIV_N_W-1:0] div_q;

	// Input fields.
	op_t                in_op;
	logic [1:0]         in_axis;
	logic signed [31:0] in_a;
	logic signed [31:0] in_b;
	logic signed [31:0] in_c;
	logic signed [31:0] in_d;
	logic [15:0]        in_delta;
	logic               in_xfer;
	logic               out_free;

	assign in_op    = op_t'(s_axis_tuser[1:0]);
	assign in_axis  = s_axis_tuser[3:2];
	assign in_a     = s_axis_tdata[31:0];
	assign in_b     = s_axis_tdata[63:32];
	assign in_c     = s_axis_tdata[95:64];
	assign in_d     = s_axis_tdata[127:96];
	assign in_delta = s_axis_tdata[143:128];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	// Integration step k: which rate drives which value. Each axis updates its
	// position before its velocity, so the position uses the old velocity.
	logic signed [31:0] rate_sel;
	logic signed [31:0] val_sel;

	always_comb begin
		case (k_q)
			3'd0: begin rate_sel = vel_q[0]; val_sel = pos_q[0]; end
			3'd1: begin rate_sel = acc_q[0]; val_sel = vel_q[0]; end
			3'd2: begin rate_sel = vel_q[1]; val_sel = pos_q[1]; end
			3'd3: begin rate_sel = acc_q[1]; val_sel = vel_q[1]; end
			3'd4: begin rate_sel = vel_q[2]; val_sel = pos_q[2]; end
			3'd5: begin rate_sel = acc_q[2]; val_sel = vel_q[2]; end
			3'd6: begin rate_sel = spin_q;   val_sel = rot_q;    end
			default: begin rate_sel = grow_q; val_sel = siz_q;   end
		endcase
	end

	// Magnitude of the rate; the divided step gets its sign back afterwards.
	logic [31:0] rate_mag;
	assign rate_mag = rate_sel[31] ? 32'(-rate_sel) : rate_sel;

	// The step is round(|rate*delta| / 1000), applied with the rate's sign and
	// saturated to the 32-bit signed range.
	logic signed [39:0] step_sum;
	logic [39:0]        step_q;
	logic signed [31:0] step_res;

	assign step_q   = div_q[39:0];
	assign step_sum = 40'(val_sel) + (rate_sel[31] ? -$signed(step_q) : $signed(step_q));

	always_comb begin
		if (step_sum > 40'sh007FFFFFFF) begin
			step_res = 32'h7FFFFFFF;
		end else if (step_sum < -40'sh0080000000) begin
			step_res = 32'h80000000;
		end else begin
			step_res = step_sum[31:0];
		end
	end

	// Fade span and numerator: span = finish - begin, num = elapsed*65536 - begin*life.
	logic signed [17:0] span;
	logic [16:0]        span_mag;
	logic               den_neg;
	logic signed [49:0] num;
	logic [48:0]        num_mag;

	assign span     = $signed({1'b0, ffinish_q}) - $signed({1'b0, fbegin_q});
	assign span_mag = span[17] ? 17'(-span) : span[16:0];
	assign den_neg  = span[17];
	assign num      = $signed({2'b00, elapsed_q, 16'h0000}) - $signed({9'd0, bl_q});
	assign num_mag  = num[49] ? 49'(-num) : num[48:0];

	// Scaled fraction: t = (r*rate + 128) >> 8, limited to 512.0.
	logic [50:0] t_round;
	logic [42:0] t_full;
	assign t_round = {1'b0, mul_p[49:0]} + 51'd128;
	assign t_full  = t_round[50:8];

	// Channel lerp for channel ch_q.
	logic [7:0]         ch_s;
	logic [7:0]         ch_g;
	logic signed [8:0]  ch_diff;
	logic [7:0]         ch_mag;
	logic signed [35:0] ch_v;
	logic [33:0]        ch_prod;
	logic [7:0]         ch_res;

	assign ch_s    = start_q[{ch_q, 3'b000} +: 8];
	assign ch_g    = target_q[{ch_q, 3'b000} +: 8];
	assign ch_diff = $signed({1'b0, ch_g}) - $signed({1'b0, ch_s});
	assign ch_mag  = ch_diff[8] ? 8'(-ch_diff) : ch_diff[7:0];
	assign ch_prod = mul_p[33:0];
	assign ch_v    = $signed({12'd0, ch_s, 16'h8000})
		+ ((t_neg_q ^ ch_diff[8]) ? -$signed({2'b00, ch_prod}) : $signed({2'b00, ch_prod}));

	always_comb begin
		if (ch_v[35]) begin
			ch_res = 8'd0;
		end else if (ch_v[34:24] != '0) begin
			ch_res = 8'hFF;
		end else begin
			ch_res = ch_v[23:16];
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_nxt = (in_op == OP_TICK) ? S_AMUL : S_WB;
				end
			end
			S_AMUL:   state_nxt = S_AMUL_W;
			S_AMUL_W: if (mul_st.done) state_nxt = S_ADIV;
			S_ADIV:   state_nxt = S_ADIV_W;
			S_ADIV_W: if (div_st.done) state_nxt = S_AWB;
			S_AWB: begin
				if (k_q != 3'd7) begin
					state_nxt = S_AMUL;
				end else begin
					state_nxt = fon_q ? S_F_BL : S_WB;
				end
			end
			S_F_BL:    state_nxt = S_F_BL_W;
			S_F_BL_W:  if (mul_st.done) state_nxt = S_F_DEN;
			S_F_DEN:   state_nxt = S_F_DEN_W;
			S_F_DEN_W: if (mul_st.done) state_nxt = S_F_NUM;
			S_F_NUM:   state_nxt = (d_q == '0) ? S_F_CH : S_FDIV_W;
			S_FDIV_W:  if (div_st.done) state_nxt = S_F_T;
			S_F_T:     state_nxt = S_F_T_W;
			S_F_T_W:   if (mul_st.done) state_nxt = S_F_CH;
			S_F_CH:    state_nxt = S_F_CH_W;
			S_F_CH_W: begin
				if (mul_st.done) begin
					state_nxt = (ch_q == 2'd3) ? S_WB : S_F_CH;
				end
			end
			S_WB:    if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Unit commands and handshake outputs.
	always_comb begin
		mul_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		div_start     = 1'b0;
		div_n         = '0;
		div_d         = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_AMUL: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(rate_mag);
				mul_b     = MUL_B_W'(delta_q);
			end
			S_ADIV: begin
				div_start = 1'b1;
				div_n     = DIV_N_W'(mul_p[47:0]) + STEP_HALF;
				div_d     = STEP_DIV;
			end
			S_F_BL: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(fbegin_q);
				mul_b     = life_q;
			end
			S_F_DEN: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(span_mag);
				mul_b     = life_q;
			end
			S_F_NUM: begin
				div_start = (d_q != '0);
				div_n     = {1'b0, num_mag, 16'h0000};
				div_d     = DIV_D_W'(d_q);
			end
			S_F_T: begin
				mul_start = 1'b1;
				mul_a     = r_q;
				mul_b     = MUL_B_W'(frate_q);
			end
			S_F_CH: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(t_mag_q);
				mul_b     = MUL_B_W'(ch_mag);
			end
			default: begin
			end
		endcase
	end

	// Configuration, particle state and sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q      <= 24'd4000;
			fbegin_q    <= '0;
			ffinish_q   <= 17'h10000;
			frate_q     <= 16'd256;
			fon_q       <= 1'b1;
			start_q     <= '0;
			target_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
				old_q[i] <= '0;
			end
			rot_q       <= '0;
			spin_q      <= '0;
			siz_q       <= SIZE_RESET;
			grow_q      <= '0;
			elapsed_q   <= '0;
			colour_q    <= '0;
			state_q     <= S_IDLE;
			k_q         <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LIFE:    life_q    <= cfg_data[23:0];
					CFG_FBEGIN:  fbegin_q  <= cfg_data[16:0];
					CFG_FFINISH: ffinish_q <= cfg_data[16:0];
					CFG_FRATE:   frate_q   <= cfg_data[15:0];
					CFG_FON:     fon_q     <= cfg_data[0];
					CFG_START:   start_q   <= cfg_data;
					CFG_TARGET:  target_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			// A new result may replace one that leaves in the same cycle.
			if (state_q == S_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						k_q  <= '0;
						ch_q <= '0;
						case (in_op)
							OP_TICK: begin
								for (int i = 0; i < 3; i++) begin
									old_q[i] <= pos_q[i];
								end
								// Elapsed time saturates at its full range.
								if (({1'b0, elapsed_q} + {17'd0, in_delta}) > 33'hFFFFFFFF) begin
									elapsed_q <= '1;
								end else begin
									elapsed_q <= elapsed_q + {16'd0, in_delta};
								end
							end
							OP_LOAD_AXIS: begin
								if (in_axis != 2'd3) begin
									pos_q[in_axis] <= in_a;
									vel_q[in_axis] <= in_b;
									acc_q[in_axis] <= in_c;
								end
							end
							OP_LOAD_SPIN: begin
								rot_q  <= in_a;
								spin_q <= in_b;
								siz_q  <= in_c;
								grow_q <= in_d;
							end
							default: elapsed_q <= '0;
						endcase
					end
				end
				S_AWB: begin
					k_q <= k_q + 3'd1;
					case (k_q)
						3'd0: pos_q[0] <= step_res;
						3'd1: vel_q[0] <= step_res;
						3'd2: pos_q[1] <= step_res;
						3'd3: vel_q[1] <= step_res;
						3'd4: pos_q[2] <= step_res;
						3'd5: vel_q[2] <= step_res;
						3'd6: rot_q    <= step_res;
						default: siz_q <= step_res;
					endcase
				end
				S_F_CH_W: begin
					if (mul_st.done) begin
						colour_q[{ch_q, 3'b000} +: 8] <= ch_res;
						ch_q <= ch_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Fade datapath and result register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			delta_q <= in_delta;
		end
		if (state_q == S_F_BL_W && mul_st.done) begin
			bl_q <= mul_p[40:0];
		end
		if (state_q == S_F_DEN_W && mul_st.done) begin
			d_q <= mul_p[40:0];
		end
		if (state_q == S_F_NUM) begin
			num_neg_q <= num[49];
			if (d_q == '0) begin
				// Zero fade span or lifetime: the fraction saturates with the numerator's sign.
				t_mag_q <= T_MAX;
				t_neg_q <= num[49];
			end
		end
		if (state_q == S_FDIV_W && div_st.done) begin
			r_q <= (div_q[DIV_N_W-1:33] != '0) ? (34'(1) << 33) : div_q[33:0];
		end
		if (state_q == S_F_T_W && mul_st.done) begin
			t_mag_q <= (t_full > 43'(T_MAX)) ? T_MAX : t_full[25:0];
			t_neg_q <= num_neg_q ^ den_neg;
		end
		if (state_q == S_WB && out_free) begin
			out_q <= {elapsed_q, colour_q, siz_q, rot_q, old_q[2], old_q[1], old_q[0],
				pos_q[2], pos_q[1], pos_q[0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	pkfu_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.a        (mul_a),
		.b        (mul_b),
		.stat     (mul_st),
		.prod     (mul_p)
	);

	pkfu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.stat     (div_st),
		.quotient (div_q)
	);

	`PKFU_ASSERT_SAME(a_mul_free, mul_start, !mul_st.busy, "multiplier started while busy")
	`PKFU_ASSERT_SAME(a_div_owner, div_st.done, (state_q == S_ADIV_W) || (state_q == S_FDIV_W), "divider finished outside a divide wait")
	`PKFU_ASSERT_NEXT(a_item_leaves_idle, in_xfer, state_q != S_IDLE, "sequencer stayed idle after a transfer")
	`PKFU_ASSERT_SAME(a_result_from_wb, $rose(m_axis_tvalid), $past(state_q == S_WB), "result raised outside write-back")

endmodule

[sim/particle_kinematics_fade_update_top_tb.sv]
module particle_kinematics_fade_update_top_tb import pkfu_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// One particle snapshot as the block reports it after each item.
	typedef struct {
		logic [31:0] word [10];
	} snapshot_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// value_a, value_b, value_c, value_d, delta_ms from the lowest bit up.
	logic [143:0] s_axis_tdata;
	// operation, axis from the lowest bit up.
	logic [3:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// pos_x..z, prev_x..z, angle, extent, colour_out, elapsed_out from the lowest bit up.
	logic [319:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	particle_kinematics_fade_update_top dut (.*);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow copy of the configuration registers.
	logic [23:0] life_ms;
	logic [16:0] begin_frac;
	logic [16:0] finish_frac;
	logic [15:0] fade_speed;
	logic        fade_enable;
	logic [31:0] colour_from;
	logic [31:0] colour_to;

	// Shadow copy of the particle state.
	logic signed [31:0] pos [3];
	logic signed [31:0] vel [3];
	logic signed [31:0] acc [3];
	logic signed [31:0] last_pos [3];
	logic signed [31:0] rot;
	logic signed [31:0] spin;
	logic signed [31:0] sz;
	logic signed [31:0] grow;
	logic [31:0]        elapsed_ms;
	logic [31:0]        colour_now;

	snapshot_t snapshots_due [$];
	int  mismatches;
	bit  calm;           // set for the final stretch of the run: no idling on either side
	int  stall_left;

	// Integrates one quantity over delta milliseconds: rate*delta/1000, rounded
	// to nearest with ties away from zero, then saturated to 32-bit signed.
	function automatic logic signed [31:0] integrate(logic signed [31:0] value,
			logic signed [31:0] rate, logic [15:0] delta);
		longint p, q, sum;
		longint unsigned mag;
		p = longint'(rate) * longint'({16'd0, delta});
		mag = (p < 0) ? longint'(-p) : p;
		q = longint'((mag + 64'd500) / 64'd1000);
		sum = longint'(value) + ((p < 0) ? -q : q);
		if (sum > 64'sd2147483647)
			return 32'sh7fffffff;
		if (sum < -64'sd2147483648)
			return 32'sh80000000;
		return sum[31:0];
	endfunction

	// Fade fraction in Q16.16, signed, limited to +/-512.0.
	function automatic longint fade_fraction();
		longint den, num;
		longint unsigned n, d, r, t;
		bit neg;
		den = (longint'({15'd0, finish_frac}) - longint'({15'd0, begin_frac}))
			* longint'({8'd0, life_ms});
		num = longint'({32'd0, elapsed_ms}) * 65536
			- longint'({15'd0, begin_frac}) * longint'({8'd0, life_ms});
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		if (d == 0)
			return (num < 0) ? -(64'sd1 << 25) : (64'sd1 << 25);
		neg = (num < 0) != (den < 0);
		if (n / d >= (64'd1 << 17))
			r = 64'd1 << 33;
		else
			r = ((n / d) << 16) + (((n % d) << 16) / d);
		t = (r * fade_speed + 64'd128) >> 8;
		if (t > (64'd1 << 25))
			t = 64'd1 << 25;
		return neg ? -longint'(t) : longint'(t);
	endfunction

	// Per-channel lerp from the start to the target colour, clamped to 0..255.
	function automatic logic [31:0] faded_colour();
		longint t, s, g, v;
		logic [31:0] mix;
		t = fade_fraction();
		mix = '0;
		for (int sh = 0; sh < 32; sh += 8) begin
			s = (colour_from >> sh) & 32'hff;
			g = (colour_to >> sh) & 32'hff;
			v = (s * 65536 + (g - s) * t + 32768) >>> 16;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			mix |= 32'(v) << sh;
		end
		return mix;
	endfunction

	// Applies one item to the shadow state and returns the snapshot it yields.
	function automatic snapshot_t particle_after(op_t op, logic [1:0] axis,
			logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c,
			logic signed [31:0] d, logic [15:0] delta);
		snapshot_t snap;
		case (op)
			OP_TICK: begin
				for (int i = 0; i < 3; i++) begin
					last_pos[i] = pos[i];
					pos[i] = integrate(pos[i], vel[i], delta);
					vel[i] = integrate(vel[i], acc[i], delta);
				end
				rot = integrate(rot, spin, delta);
				sz = integrate(sz, grow, delta);
				elapsed_ms = (elapsed_ms > 32'hffffffff - delta) ? 32'hffffffff
					: elapsed_ms + delta;
				if (fade_enable)
					colour_now = faded_colour();
			end
			OP_LOAD_AXIS: begin
				// Axis 3 selects nothing and leaves the state alone.
				if (axis < 3) begin
					pos[axis] = a;
					vel[axis] = b;
					acc[axis] = c;
				end
			end
			OP_LOAD_SPIN: begin
				rot = a;
				spin = b;
				sz = c;
				grow = d;
			end
			default: elapsed_ms = '0;
		endcase
		for (int i = 0; i < 3; i++) begin
			snap.word[i] = pos[i];
			snap.word[3 + i] = last_pos[i];
		end
		snap.word[6] = rot;
		snap.word[7] = sz;
		snap.word[8] = colour_now;
		snap.word[9] = elapsed_ms;
		return snap;
	endfunction

	// Sends one item. The valid stays high from one transfer into the next
	// unless an idle burst is drawn, so it is never lowered and raised in one step.
	task automatic send_item(op_t op, logic [1:0] axis, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d, logic [15:0] delta);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {delta, d, c, b, a};
		s_axis_tuser  <= {axis, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// The transfer happened at this edge.
		snapshots_due.push_back(particle_after(op, axis, a, b, c, d, delta));
	endtask

	// Waits until every pending snapshot has arrived, then a few cycles more.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (snapshots_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one configuration register; only called while the block is idle.
	// The caller lowers the valid after its last write.
	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_LIFE:    life_ms = value[23:0];
			CFG_FBEGIN:  begin_frac = value[16:0];
			CFG_FFINISH: finish_frac = value[16:0];
			CFG_FRATE:   fade_speed = value[15:0];
			CFG_FON:     fade_enable = value[0];
			CFG_START:   colour_from = value;
			CFG_TARGET:  colour_to = value;
			default: ;
		endcase
	endtask

	task automatic set_fade(logic [23:0] life, logic [16:0] fb, logic [16:0] ff,
			logic [15:0] rate, logic on, logic [31:0] from, logic [31:0] to);
		drain();
		write_reg(CFG_LIFE, 32'(life));
		write_reg(CFG_FBEGIN, 32'(fb));
		write_reg(CFG_FFINISH, 32'(ff));
		write_reg(CFG_FRATE, 32'(rate));
		write_reg(CFG_FON, 32'(on));
		write_reg(CFG_START, from);
		write_reg(CFG_TARGET, to);
		cfg_valid <= 1'b0;
	endtask

	// Mostly moderate values so that integration stays out of saturation,
	// with full-range words and the extremes mixed in.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom;
			4: return '0;
			default: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh1fffff);
		endcase
	endfunction

	function automatic logic [15:0] pick_delta();
		case ($urandom_range(0, 7))
			0: return 16'hffff;
			1: return 16'($urandom_range(0, 16'hffff));
			2: return '0;
			default: return 16'($urandom_range(1, 100));
		endcase
	endfunction

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			send_item(OP_TICK, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
				$urandom, pick_delta());
		else if (pick < 75)
			send_item(OP_LOAD_AXIS, 2'($urandom_range(0, 3)), pick_value(), pick_value(),
				pick_value(), $urandom, 16'($urandom));
		else if (pick < 93)
			send_item(OP_LOAD_SPIN, 2'($urandom_range(0, 3)), pick_value(), pick_value(),
				pick_value(), pick_value(), 16'($urandom));
		else
			send_item(OP_CLEAR, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
				$urandom, 16'($urandom));
	endtask

	// The state after reset is visible through a clear item.
	task automatic test_reset_state();
		send_item(OP_CLEAR, 2'd0, '0, '0, '0, '0, '0);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd0);
	endtask

	// Loads at the field extremes, ticks at both ends of delta, the unused
	// axis code, and ignored inputs carrying junk.
	task automatic test_directed_loads_and_ticks();
		send_item(OP_LOAD_AXIS, 2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'hffffffff, 16'hffff);
		send_item(OP_LOAD_AXIS, 2'd1, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h12345678, 16'h0);
		send_item(OP_LOAD_AXIS, 2'd2, 32'h00010000, 32'hfffe0000, 32'h00000800,
			32'h0, 16'h1234);
		send_item(OP_LOAD_AXIS, 2'd3, 32'hdeadbeef, 32'hdeadbeef, 32'hdeadbeef,
			32'hdeadbeef, 16'hffff);
		send_item(OP_LOAD_SPIN, 2'd3, 32'h00030000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 16'hffff);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'hffff);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd0);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd1);
		send_item(OP_LOAD_SPIN, 2'd0, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 16'd0);
		// Ties on the rounding: rate*delta ending in 500 either sign.
		send_item(OP_LOAD_AXIS, 2'd0, 32'd0, 32'd1, 32'hffffffff, 32'd0, 16'd0);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd500);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd1500);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd499);
		send_item(OP_CLEAR, 2'd1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 16'hffff);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd2000);
	endtask

	// Fade settings across the extremes: zero span, reversed span, before the
	// window, zero and full speed, shortest and longest lifetime, fading off.
	task automatic test_fade_settings();
		set_fade(24'd1000, 17'd0, 17'd65536, 16'd256, 1'b1, 32'h00000000, 32'hffffffff);
		send_item(OP_CLEAR, 2'd0, '0, '0, '0, '0, '0);
		repeat (4)
			send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd300);
		set_fade(24'd2000, 17'd32768, 17'd32768, 16'd256, 1'b1, 32'h80ff00aa, 32'h01020304);
		send_item(OP_CLEAR, 2'd0, '0, '0, '0, '0, '0);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd0);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd1500);
		set_fade(24'd16777215, 17'd65536, 17'd0, 16'd65535, 1'b1, 32'hffffffff, 32'h0);
		send_item(OP_CLEAR, 2'd0, '0, '0, '0, '0, '0);
		repeat (3)
			send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'hffff);
		set_fade(24'd1, 17'd65536, 17'd65536, 16'd0, 1'b1, 32'h12345678, 32'h87654321);
		send_item(OP_CLEAR, 2'd0, '0, '0, '0, '0, '0);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd1);
		set_fade(24'd3000, 17'd13107, 17'd52429, 16'd512, 1'b0, 32'haaaaaaaa, 32'h55555555);
		send_item(OP_TICK, 2'd0, '0, '0, '0, '0, 16'd700);
	endtask

	// Random settings between phases of random traffic.
	task automatic test_random_traffic(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			set_fade(24'($urandom_range(1, 24'hffffff) >> $urandom_range(0, 14)),
				17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
				16'($urandom_range(0, 16'hffff) >> $urandom_range(0, 8)),
				$urandom_range(0, 3) != 0, $urandom, $urandom);
			// Sender holds off once until everything outstanding has returned.
			for (int k = 0; k < per_phase; k++) begin
				random_item();
				if (k == per_phase / 2 && ph == 0)
					drain();
			end
		end
	endtask

	// Receiver stalls in random bursts, none in the final stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 11);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Each snapshot transfer is compared against the oldest pending expectation.
	always @(posedge clk) begin
		snapshot_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (snapshots_due.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected snapshot %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = snapshots_due.pop_front();
				for (int f = 0; f < 10; f++) begin
					if (m_axis_tdata[f*32 +: 32] !== want.word[f]) begin
						if (mismatches < 10)
							$display("Field %0d mismatch: expected %h, got %h", f,
								want.word[f], m_axis_tdata[f*32 +: 32]);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LIFE;
		cfg_data = '0;
		calm = 1'b0;
		mismatches = 0;
		life_ms = 24'd4000;
		begin_frac = 17'd0;
		finish_frac = 17'd65536;
		fade_speed = 16'd256;
		fade_enable = 1'b1;
		colour_from = '0;
		colour_to = '0;
		for (int i = 0; i < 3; i++) begin
			pos[i] = '0;
			vel[i] = '0;
			acc[i] = '0;
			last_pos[i] = '0;
		end
		rot = '0;
		spin = '0;
		sz = SIZE_RESET;
		grow = '0;
		elapsed_ms = '0;
		colour_now = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_loads_and_ticks();
		test_fade_settings();
		test_random_traffic(8, 200);
		// Final stretch with steady flow on both sides.
		calm = 1'b1;
		test_random_traffic(1, 60);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && snapshots_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
